@@ design/sdcr_pkg.sv @@
// shared constants, types and helpers for the sum/difference coverage reach block
package sdcr_pkg;

  // defaults for the top-level parameters
  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int VALUE_BITS_DEF   = 12;

  // coverage map row organisation: one row is read or cleared per cycle
  localparam int ROW_BITS  = 16;
  localparam int ROW_SEL_W = 4;

  // width of the reported reach
  localparam int REACH_W = 13;

  // per-transaction control flags passed from front to back
  typedef struct packed {
    logic keep;  // element goes into the store
    logic last;  // element closes the set
    logic ovf;   // an element of this set has been dropped so far
  } item_flags_t;

  localparam int FLAGS_W = $bits(item_flags_t);

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MARK_SELF,
    ST_MARK_SUM,
    ST_MARK_DIFF,
    ST_SCAN,
    ST_SCAN_END,
    ST_RESULT
  } back_state_t;

  // index of the lowest clear bit in a map row
  function automatic logic [ROW_SEL_W-1:0] first_zero(input logic [ROW_BITS-1:0] d);
    logic [ROW_SEL_W-1:0] idx;
    idx = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!d[i]) begin
        idx = ROW_SEL_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ design/sdcr_front.sv @@
// front end: accepts elements, assigns store slots and tracks overflow
module sdcr_front #(
  parameter int MAX_ELEMENTS = sdcr_pkg::MAX_ELEMENTS_DEF,
  parameter int VALUE_BITS   = sdcr_pkg::VALUE_BITS_DEF,
  parameter int SLOT_W       = $clog2(MAX_ELEMENTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  last,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  init_busy,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [VALUE_BITS-1:0] push_value,
  output logic [SLOT_W-1:0]     push_slot,
  output sdcr_pkg::item_flags_t push_flags
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [CNT_W-1:0] count;
  logic             ovf_seen;
  logic             keep;
  logic             accept;

  // classify the incoming element
  assign keep       = (count < CNT_W'(MAX_ELEMENTS));
  assign item_ready = push_ready && !init_busy;
  assign accept     = item_valid && item_ready;

  assign push_valid      = item_valid && !init_busy;
  assign push_value      = value;
  assign push_slot       = count[SLOT_W-1:0];
  assign push_flags.keep = keep;
  assign push_flags.last = last;
  assign push_flags.ovf  = ovf_seen || !keep;

  // element count and overflow tracking per set
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end else if (accept) begin
      if (last) begin
        count    <= '0;
        ovf_seen <= 1'b0;
      end else begin
        count    <= count + CNT_W'(keep);
        ovf_seen <= ovf_seen || !keep;
      end
    end
  end

endmodule

@@ design/sdcr_queue.sv @@
// two-entry queue decoupling the front end from the back end
module sdcr_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic         do_wr;
  logic         do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

@@ design/sdcr_back.sv @@
// back end: element store, coverage map marking, reach scan and result register
module sdcr_back #(
  parameter int MAX_ELEMENTS = sdcr_pkg::MAX_ELEMENTS_DEF,
  parameter int VALUE_BITS   = sdcr_pkg::VALUE_BITS_DEF,
  parameter int SLOT_W       = $clog2(MAX_ELEMENTS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [VALUE_BITS-1:0]         q_value,
  input  logic [SLOT_W-1:0]             q_slot,
  input  sdcr_pkg::item_flags_t         q_flags,
  output logic                          init_busy,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [sdcr_pkg::REACH_W-1:0]  reach,
  output logic                          overflowed
);

  localparam int MAP_W     = VALUE_BITS + 1;
  localparam int ROWS      = (1 << MAP_W) / sdcr_pkg::ROW_BITS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ROW_BITS  = sdcr_pkg::ROW_BITS;
  localparam int ROW_SEL_W = sdcr_pkg::ROW_SEL_W;

  sdcr_pkg::back_state_t state, state_next;

  // element store and coverage map
  logic [VALUE_BITS-1:0] store [MAX_ELEMENTS];
  logic [ROW_BITS-1:0]   cov_map [ROWS];
  logic [ROW_BITS-1:0]   rd_data;

  // current transaction
  logic [VALUE_BITS-1:0] cur_value;
  logic [SLOT_W-1:0]     cur_slot;
  sdcr_pkg::item_flags_t cur_flags;
  logic [SLOT_W-1:0]     k;

  // sweep and scan
  logic [ROW_W-1:0]      row_cnt;
  logic                  scan_vld;
  logic [ROW_W-1:0]      scan_row;
  logic                  found;
  logic [MAP_W-1:0]      acc;

  // map port control
  logic                  map_set;
  logic                  map_clr;
  logic [MAP_W-1:0]      mark_addr;
  logic [ROW_W-1:0]      map_row;
  logic [ROW_SEL_W-1:0]  map_bit;
  logic                  q_pop;
  logic                  out_load;

  // pair arithmetic
  logic [VALUE_BITS-1:0] elem;
  logic [MAP_W-1:0]      pair_sum;
  logic [VALUE_BITS-1:0] pair_diff;
  logic                  row_last;
  logic [ROW_BITS-1:0]   row_eff;

  assign elem      = store[k];
  assign pair_sum  = {1'b0, cur_value} + {1'b0, elem};
  assign pair_diff = (cur_value >= elem) ? (cur_value - elem) : (elem - cur_value);
  assign row_last  = (row_cnt == ROW_W'(ROWS - 1));
  assign q_pop     = q_valid && q_ready;
  assign init_busy = (state == sdcr_pkg::ST_INIT);

  // zero never counts: bit 0 of row 0 is treated as covered
  assign row_eff = rd_data | {{(ROW_BITS - 1){1'b0}}, (scan_row == '0)};

  // next state and map port control
  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    map_set    = 1'b0;
    map_clr    = 1'b0;
    mark_addr  = {1'b0, cur_value};
    out_load   = 1'b0;
    case (state)
      sdcr_pkg::ST_INIT: begin
        map_clr = 1'b1;
        if (row_last) begin
          state_next = sdcr_pkg::ST_IDLE;
        end
      end
      sdcr_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_flags.keep) begin
            state_next = sdcr_pkg::ST_MARK_SELF;
          end else if (q_flags.last) begin
            state_next = sdcr_pkg::ST_SCAN;
          end
        end
      end
      sdcr_pkg::ST_MARK_SELF: begin
        map_set    = 1'b1;
        mark_addr  = {1'b0, cur_value};
        state_next = sdcr_pkg::ST_MARK_SUM;
      end
      sdcr_pkg::ST_MARK_SUM: begin
        map_set    = 1'b1;
        mark_addr  = pair_sum;
        state_next = sdcr_pkg::ST_MARK_DIFF;
      end
      sdcr_pkg::ST_MARK_DIFF: begin
        map_set   = 1'b1;
        mark_addr = {1'b0, pair_diff};
        if (k == cur_slot) begin
          state_next = cur_flags.last ? sdcr_pkg::ST_SCAN : sdcr_pkg::ST_IDLE;
        end else begin
          state_next = sdcr_pkg::ST_MARK_SUM;
        end
      end
      sdcr_pkg::ST_SCAN: begin
        map_clr = 1'b1;
        if (row_last) begin
          state_next = sdcr_pkg::ST_SCAN_END;
        end
      end
      sdcr_pkg::ST_SCAN_END: begin
        state_next = sdcr_pkg::ST_RESULT;
      end
      sdcr_pkg::ST_RESULT: begin
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = sdcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sdcr_pkg::ST_INIT;
      end
    endcase
  end

  // row select: the sweep counter while clearing, the mark address otherwise
  assign map_row = map_clr ? row_cnt : mark_addr[MAP_W-1:ROW_SEL_W];
  assign map_bit = mark_addr[ROW_SEL_W-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdcr_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // coverage map: bit set, row clear, registered row read
  always_ff @(posedge clk) begin
    if (map_set) begin
      cov_map[map_row][map_bit] <= 1'b1;
    end else if (map_clr) begin
      cov_map[map_row] <= '0;
    end
    rd_data <= cov_map[map_row];
  end

  // element store
  always_ff @(posedge clk) begin
    if (q_pop && q_flags.keep) begin
      store[q_slot] <= q_value;
    end
  end

  // current transaction and pair index
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_value <= q_value;
      cur_slot  <= q_slot;
      cur_flags <= q_flags;
    end
    if (state == sdcr_pkg::ST_MARK_SELF) begin
      k <= '0;
    end else if (state == sdcr_pkg::ST_MARK_DIFF) begin
      k <= k + SLOT_W'(1);
    end
  end

  // row sweep counter for the reset clear and the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (map_clr) begin
      row_cnt <= row_last ? '0 : row_cnt + ROW_W'(1);
    end
  end

  // reach search over registered rows
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld <= 1'b0;
      found    <= 1'b0;
    end else begin
      scan_vld <= (state == sdcr_pkg::ST_SCAN);
      if (q_pop) begin
        found <= 1'b0;
      end else if (scan_vld && !found && (row_eff != '1)) begin
        found <= 1'b1;
      end
    end
    scan_row <= row_cnt;
    if (scan_vld && !found && (row_eff != '1)) begin
      acc <= {scan_row, sdcr_pkg::first_zero(row_eff)} - MAP_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (out_load) begin
      reach      <= sdcr_pkg::REACH_W'(found ? acc : {MAP_W{1'b1}});
      overflowed <= cur_flags.ovf;
    end
  end

  // pair index never runs past the newest element
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == sdcr_pkg::ST_MARK_SUM || state == sdcr_pkg::ST_MARK_DIFF) |-> (k <= cur_slot))
    else $error("pair index beyond stored elements");

  // scan data only arrives while scanning
  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    scan_vld |-> (state == sdcr_pkg::ST_SCAN || state == sdcr_pkg::ST_SCAN_END))
    else $error("scan data outside scan");

  // nothing leaves the queue during the reset clear
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (rst)
    (state == sdcr_pkg::ST_INIT) |-> !q_pop)
    else $error("queue popped during map clear");

  // the scan always hands over to the result stage
  a_scan_to_result: assert property (@(posedge clk) disable iff (rst)
    (state == sdcr_pkg::ST_SCAN_END) |=> (state == sdcr_pkg::ST_RESULT))
    else $error("scan did not end in result");

endmodule

@@ design/sum_difference_coverage_reach.sv @@
// Top level of the sum/difference coverage reach block.
// Sequence: a stored element is marked in the back end, then its sum and difference
// with each element held (itself included); a dropped element only leaves the queue.
// The closing element adds a sweep of ROWS rows (ROWS = 2^(VALUE_BITS+1)/16, 512 by
// default) to scan and clear the coverage map. One map write per cycle sets the rate.
// Reset: synchronous; a map clearing pass over all ROWS rows follows, item_ready stays low.
module sum_difference_coverage_reach #(
  parameter int MAX_ELEMENTS = sdcr_pkg::MAX_ELEMENTS_DEF,
  parameter int VALUE_BITS   = sdcr_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [VALUE_BITS-1:0]        value,
  input  logic                         last,
  input  logic                         item_valid,
  output logic                         item_ready,
  output logic [sdcr_pkg::REACH_W-1:0] reach,
  output logic                         overflowed,
  output logic                         result_valid,
  input  logic                         result_ready
);

  localparam int SLOT_W = $clog2(MAX_ELEMENTS);
  localparam int Q_W    = sdcr_pkg::FLAGS_W + SLOT_W + VALUE_BITS;

  logic                  init_busy;
  logic                  push_valid;
  logic                  push_ready;
  logic [VALUE_BITS-1:0] push_value;
  logic [SLOT_W-1:0]     push_slot;
  sdcr_pkg::item_flags_t push_flags;
  logic                  q_valid;
  logic                  q_ready;
  logic [Q_W-1:0]        q_data;
  logic [VALUE_BITS-1:0] q_value;
  logic [SLOT_W-1:0]     q_slot;
  sdcr_pkg::item_flags_t q_flags;

  // accept and classify
  sdcr_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS),
    .SLOT_W       (SLOT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .last       (last),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .init_busy  (init_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_value (push_value),
    .push_slot  (push_slot),
    .push_flags (push_flags)
  );

  // decoupling queue
  sdcr_queue #(
    .W (Q_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_flags, push_slot, push_value}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_value = q_data[VALUE_BITS-1:0];
  assign q_slot  = q_data[VALUE_BITS +: SLOT_W];
  assign q_flags = q_data[Q_W-1 -: sdcr_pkg::FLAGS_W];

  // marking, scan and result
  sdcr_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS),
    .SLOT_W       (SLOT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_value      (q_value),
    .q_slot       (q_slot),
    .q_flags      (q_flags),
    .init_busy    (init_busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .reach        (reach),
    .overflowed   (overflowed)
  );

endmodule
